/* rtl/core/assert_macros.svh */
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle, off during reset
`define AST_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle, checked through reset too
`define AST_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/mxa_pkg.sv */
// types, constants and helpers of the 2x2 fixed point matrix unit
`default_nettype none
package mxa_pkg;
    localparam int FRAC_BITS = 16;
    localparam int SUM_W     = 65 - FRAC_BITS;
    localparam int NUM_W     = 33 + FRAC_BITS;
    localparam int MAG_W     = (NUM_W > SUM_W) ? NUM_W : SUM_W;
    localparam int Q_W       = 33;
    localparam int LAT       = 3 + Q_W + 2;

    localparam logic signed [31:0] Q_ONE = 32'(64'd1 << FRAC_BITS);
    localparam logic signed [SUM_W-1:0] S_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] S_MIN = SUM_W'(-64'sd2147483648);

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_SCL = 3'd2;
    localparam logic [2:0] OP_MUL = 3'd3;
    localparam logic [2:0] OP_DET = 3'd4;
    localparam logic [2:0] OP_INV = 3'd5;
    localparam logic [2:0] OP_EQ  = 3'd6;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] a_00;
        logic signed [31:0] a_01;
        logic signed [31:0] a_10;
        logic signed [31:0] a_11;
        logic signed [31:0] b_00;
        logic signed [31:0] b_01;
        logic signed [31:0] b_10;
        logic signed [31:0] b_11;
        logic signed [31:0] scale_factor;
        logic [30:0]        tolerance;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] r_00;
        logic signed [31:0] r_01;
        logic signed [31:0] r_10;
        logic signed [31:0] r_11;
        logic               flag;
    } t_out_item;

    // operands of one lane: floor(x1*y1) +/- floor(x2*y2)
    typedef struct packed {
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
        logic               sub;
    } t_lane_op;

    // clamp a wide lane sum to the signed 32-bit range
    function automatic logic signed [31:0] sat_sum(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] res;
        if (v > S_MAX) begin
            res = 32'sh7fffffff;
        end else if (v < S_MIN) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction
endpackage
`default_nettype wire

/* rtl/core/mxa_lane.sv */
// one element lane: two registered products, floored and combined
`default_nettype none
module mxa_lane (
    input  wire logic                              i_clk,
    input  wire mxa_pkg::t_lane_op                 i_op,
    output logic signed [mxa_pkg::SUM_W-1:0]       o_sum
);
    mxa_pkg::t_lane_op  r_op;
    logic signed [63:0] r_p;
    logic signed [63:0] r_q;
    logic               r_sub;
    logic signed [mxa_pkg::SUM_W-1:0] n_sum;
    logic signed [63:0] fp;
    logic signed [63:0] fq;

    // operand register
    always_ff @(posedge i_clk) begin
        r_op <= i_op;
    end

    // product register
    always_ff @(posedge i_clk) begin
        r_p   <= 64'(r_op.x1) * 64'(r_op.y1);
        r_q   <= 64'(r_op.x2) * 64'(r_op.y2);
        r_sub <= r_op.sub;
    end

    // floor by arithmetic shift, then add or subtract
    always_comb begin
        fp    = r_p >>> mxa_pkg::FRAC_BITS;
        fq    = r_q >>> mxa_pkg::FRAC_BITS;
        n_sum = r_sub ? (mxa_pkg::SUM_W'(fp) - mxa_pkg::SUM_W'(fq))
                      : (mxa_pkg::SUM_W'(fp) + mxa_pkg::SUM_W'(fq));
    end

    always_ff @(posedge i_clk) begin
        o_sum <= n_sum;
    end
endmodule
`default_nettype wire

/* rtl/core/mxa_div.sv */
// pipelined restoring divider, one quotient bit per stage, floor and clamp at the end
`default_nettype none
module mxa_div (
    input  wire logic                              i_clk,
    input  wire logic signed [mxa_pkg::NUM_W-1:0]  i_num,
    input  wire logic signed [mxa_pkg::SUM_W-1:0]  i_den,
    output logic signed [31:0]                     o_quot
);
    localparam int MW = mxa_pkg::MAG_W;
    localparam int QW = mxa_pkg::Q_W;

    logic [MW-1:0] r_n   [QW+1];
    logic [MW-1:0] r_d   [QW+1];
    logic [MW-1:0] r_rem [QW+1];
    logic [QW-1:0] r_q   [QW+1];
    logic          r_neg [QW+1];
    logic          r_ovf [QW+1];

    logic signed [MW:0] n_ext;
    logic signed [MW:0] d_ext;
    logic [MW-1:0]      n_abs;
    logic [MW-1:0]      d_abs;
    logic [MW-1:0]      n_top;

    // magnitudes, sign and quotient overflow check
    always_comb begin
        n_ext = (MW+1)'(i_num);
        d_ext = (MW+1)'(i_den);
        n_abs = n_ext[MW] ? MW'(-n_ext) : MW'(n_ext);
        d_abs = d_ext[MW] ? MW'(-d_ext) : MW'(d_ext);
        n_top = n_abs >> QW;
    end

    always_ff @(posedge i_clk) begin
        r_n[0]   <= n_abs;
        r_d[0]   <= d_abs;
        r_rem[0] <= n_top;
        r_q[0]   <= '0;
        r_neg[0] <= n_ext[MW] ^ d_ext[MW];
        r_ovf[0] <= (n_top >= d_abs);
    end

    // one quotient bit per stage
    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [MW:0] t;
        logic        ge;
        always_comb begin
            t  = {r_rem[s], r_n[s][QW-1-s]};
            ge = (t >= {1'b0, r_d[s]});
        end
        always_ff @(posedge i_clk) begin
            r_n[s+1]   <= r_n[s];
            r_d[s+1]   <= r_d[s];
            r_rem[s+1] <= ge ? MW'(t - {1'b0, r_d[s]}) : MW'(t);
            r_q[s+1]   <= {r_q[s][QW-2:0], ge};
            r_neg[s+1] <= r_neg[s];
            r_ovf[s+1] <= r_ovf[s];
        end
    end

    // floor toward negative infinity and clamp
    logic signed [QW+1:0] qe;
    logic signed [QW+1:0] val;
    logic signed [31:0]   n_quot;
    always_comb begin
        qe  = {2'b00, r_q[QW]};
        if (r_neg[QW]) begin
            val = (r_rem[QW] != '0) ? ~qe : -qe;
        end else begin
            val = qe;
        end
        if (r_ovf[QW]) begin
            n_quot = r_neg[QW] ? 32'sh80000000 : 32'sh7fffffff;
        end else if (val > (QW+2)'(64'sd2147483647)) begin
            n_quot = 32'sh7fffffff;
        end else if (val < (QW+2)'(-64'sd2147483648)) begin
            n_quot = 32'sh80000000;
        end else begin
            n_quot = val[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_quot <= n_quot;
    end
endmodule
`default_nettype wire

/* rtl/core/matrix2x2_fixed_alu_core.sv */
// top level of the 2x2 fixed point matrix unit: lanes, dividers and merge
//
// channel   direction  handshake           payload
// command   in         start high, busy    i_item  (mxa_pkg::t_in_item)
// result    out        o_valid strobe      o_result (mxa_pkg::t_out_item)
//
// one transaction accepted every cycle; busy is always low
// each result appears after its command, in order
// latency is set by the four-lane product stages and the 33-stage divider
// synchronous active-low reset clears the valid pipeline only
// the receiver cannot stall, results are shown for one cycle
`default_nettype none
module matrix2x2_fixed_alu_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire mxa_pkg::t_in_item   i_item,
    output logic                     o_valid,
    output mxa_pkg::t_out_item       o_result
);
    localparam int DL = mxa_pkg::Q_W + 2;

    logic [mxa_pkg::LAT-1:0] r_vld;
    mxa_pkg::t_in_item  r_item [3];
    mxa_pkg::t_out_item r_early [DL];
    logic               r_div_sel [DL];

    mxa_pkg::t_lane_op lane_op [4];
    logic signed [mxa_pkg::SUM_W-1:0] lane_sum [4];
    logic signed [mxa_pkg::NUM_W-1:0] num [4];
    logic signed [31:0] quot [4];

    logic signed [31:0] a [4];
    logic signed [31:0] b [4];
    mxa_pkg::t_out_item n_early;
    logic               n_div_sel;

    assign busy = 1'b0;

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[mxa_pkg::LAT-2:0], start};
        end
    end

    // operand selection per lane
    always_comb begin
        a[0] = i_item.a_00; a[1] = i_item.a_01; a[2] = i_item.a_10; a[3] = i_item.a_11;
        b[0] = i_item.b_00; b[1] = i_item.b_01; b[2] = i_item.b_10; b[3] = i_item.b_11;
        for (int k = 0; k < 4; k++) begin
            lane_op[k] = '0;
            case (i_item.opcode)
                mxa_pkg::OP_ADD, mxa_pkg::OP_SUB, mxa_pkg::OP_EQ: begin
                    lane_op[k].x1  = a[k];
                    lane_op[k].y1  = mxa_pkg::Q_ONE;
                    lane_op[k].x2  = b[k];
                    lane_op[k].y2  = mxa_pkg::Q_ONE;
                    lane_op[k].sub = (i_item.opcode != mxa_pkg::OP_ADD);
                end
                mxa_pkg::OP_SCL: begin
                    lane_op[k].x1 = a[k];
                    lane_op[k].y1 = i_item.scale_factor;
                end
                mxa_pkg::OP_MUL: begin
                    lane_op[k].x1 = a[(k/2)*2];
                    lane_op[k].y1 = b[k%2];
                    lane_op[k].x2 = a[(k/2)*2+1];
                    lane_op[k].y2 = b[2+(k%2)];
                end
                mxa_pkg::OP_DET, mxa_pkg::OP_INV: begin
                    lane_op[k].x1  = a[0];
                    lane_op[k].y1  = a[3];
                    lane_op[k].x2  = a[1];
                    lane_op[k].y2  = a[2];
                    lane_op[k].sub = 1'b1;
                end
                default: begin
                    lane_op[k] = '0;
                end
            endcase
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_lane
        mxa_lane u_lane (
            .i_clk (i_clk),
            .i_op  (lane_op[k]),
            .o_sum (lane_sum[k])
        );
        mxa_div u_div (
            .i_clk  (i_clk),
            .i_num  (num[k]),
            .i_den  (lane_sum[0]),
            .o_quot (quot[k])
        );
    end

    // command fields follow the lanes
    always_ff @(posedge i_clk) begin
        r_item[0] <= i_item;
        r_item[1] <= r_item[0];
        r_item[2] <= r_item[1];
    end

    // cofactor numerators for the inverse
    always_comb begin
        num[0] =   mxa_pkg::NUM_W'(r_item[2].a_11) <<< mxa_pkg::FRAC_BITS;
        num[1] = (-mxa_pkg::NUM_W'(r_item[2].a_01)) <<< mxa_pkg::FRAC_BITS;
        num[2] = (-mxa_pkg::NUM_W'(r_item[2].a_10)) <<< mxa_pkg::FRAC_BITS;
        num[3] =   mxa_pkg::NUM_W'(r_item[2].a_00) <<< mxa_pkg::FRAC_BITS;
    end

    // merge of the lane results that need no division
    logic signed [mxa_pkg::SUM_W-1:0] dabs;
    logic                             eq_ok;
    always_comb begin
        n_early   = '0;
        n_div_sel = 1'b0;
        eq_ok     = 1'b1;
        dabs      = '0;
        for (int k = 0; k < 4; k++) begin
            dabs = lane_sum[k][mxa_pkg::SUM_W-1] ? -lane_sum[k] : lane_sum[k];
            if (dabs > mxa_pkg::SUM_W'(r_item[2].tolerance)) begin
                eq_ok = 1'b0;
            end
        end
        case (r_item[2].opcode)
            mxa_pkg::OP_ADD, mxa_pkg::OP_SUB, mxa_pkg::OP_SCL, mxa_pkg::OP_MUL: begin
                n_early.r_00 = mxa_pkg::sat_sum(lane_sum[0]);
                n_early.r_01 = mxa_pkg::sat_sum(lane_sum[1]);
                n_early.r_10 = mxa_pkg::sat_sum(lane_sum[2]);
                n_early.r_11 = mxa_pkg::sat_sum(lane_sum[3]);
            end
            mxa_pkg::OP_DET: begin
                n_early.r_00 = mxa_pkg::sat_sum(lane_sum[0]);
            end
            mxa_pkg::OP_INV: begin
                n_early.flag = (lane_sum[0] == '0);
                n_div_sel    = (lane_sum[0] != '0);
            end
            mxa_pkg::OP_EQ: begin
                n_early.flag = eq_ok;
            end
            default: begin
                n_early = '0;
            end
        endcase
    end

    // delay line that runs beside the dividers
    always_ff @(posedge i_clk) begin
        r_early[0]   <= n_early;
        r_div_sel[0] <= n_div_sel;
        for (int s = 1; s < DL; s++) begin
            r_early[s]   <= r_early[s-1];
            r_div_sel[s] <= r_div_sel[s-1];
        end
    end

    // final result select
    always_comb begin
        o_valid = r_vld[mxa_pkg::LAT-1];
        if (r_div_sel[DL-1]) begin
            o_result.r_00 = quot[0];
            o_result.r_01 = quot[1];
            o_result.r_10 = quot[2];
            o_result.r_11 = quot[3];
            o_result.flag = 1'b0;
        end else begin
            o_result = r_early[DL-1];
        end
    end
endmodule
`default_nettype wire

/* rtl/core/mxa_checker.sv */
// port-level checker for the matrix unit, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module mxa_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid
);
    // every accepted transaction gives a result after the fixed latency
    `AST_IMPLY(a_lat, i_clk, i_rst_n, start && !busy, ##(mxa_pkg::LAT) o_valid)
    // no result without an accepted transaction at the matching cycle
    `AST_IMPLY(a_src, i_clk, i_rst_n, o_valid, $past(start, mxa_pkg::LAT))
    // commands are never refused
    `AST_IMPLY(a_busy, i_clk, i_rst_n, 1'b1, !busy)
    // reset clears the result strobe
    `AST_NEXT(a_rst, i_clk, !i_rst_n, !o_valid)
endmodule

bind matrix2x2_fixed_alu_core mxa_checker u_mxa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);
`default_nettype wire

/* sim/matrix2x2_fixed_alu_core_tb.sv */
// testbench for the 2x2 fixed point matrix unit: random and directed commands, checked results
`timescale 1ns / 1ps
`default_nettype none
module matrix2x2_fixed_alu_core_tb;
    import mxa_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int DRAIN_CYCLES    = LAT + 10;
    localparam int RANDOM_ITEMS    = 1000;

    // golden matrix arithmetic with its own queue of expected results
    class matrix_scoreboard;
        t_out_item pending[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        static function longint sat_word(longint v);
            longint res;
            if (v > 64'sd2147483647) begin
                res = 64'sd2147483647;
            end else if (v < -64'sd2147483648) begin
                res = -64'sd2147483648;
            end else begin
                res = v;
            end
            return res;
        endfunction

        // full product rounded toward negative infinity
        static function longint fix_mul(longint x, longint y);
            longint p;
            p = x * y;
            return p >>> FRAC_BITS;
        endfunction

        static function longint floor_quot(longint n, longint d);
            longint q;
            longint r;
            q = n / d;
            r = n % d;
            if (r != 0 && ((r < 0) != (d < 0))) q = q - 1;
            return q;
        endfunction

        function void note_command(t_in_item c);
            t_out_item e;
            longint    a[4];
            longint    b[4];
            longint    r[4];
            longint    det;
            longint    diff;
            longint    one;
            a[0] = c.a_00; a[1] = c.a_01; a[2] = c.a_10; a[3] = c.a_11;
            b[0] = c.b_00; b[1] = c.b_01; b[2] = c.b_10; b[3] = c.b_11;
            r = '{0, 0, 0, 0};
            e.flag = 1'b0;
            one = longint'(1) << FRAC_BITS;
            case (c.opcode)
                OP_ADD: for (int i = 0; i < 4; i++) r[i] = sat_word(a[i] + b[i]);
                OP_SUB: for (int i = 0; i < 4; i++) r[i] = sat_word(a[i] - b[i]);
                OP_SCL: begin
                    for (int i = 0; i < 4; i++)
                        r[i] = sat_word(fix_mul(a[i], longint'(c.scale_factor)));
                end
                OP_MUL: begin
                    r[0] = sat_word(fix_mul(a[0], b[0]) + fix_mul(a[1], b[2]));
                    r[1] = sat_word(fix_mul(a[0], b[1]) + fix_mul(a[1], b[3]));
                    r[2] = sat_word(fix_mul(a[2], b[0]) + fix_mul(a[3], b[2]));
                    r[3] = sat_word(fix_mul(a[2], b[1]) + fix_mul(a[3], b[3]));
                end
                OP_DET: r[0] = sat_word(fix_mul(a[0], a[3]) - fix_mul(a[1], a[2]));
                OP_INV: begin
                    det = fix_mul(a[0], a[3]) - fix_mul(a[1], a[2]);
                    if (det == 0) begin
                        e.flag = 1'b1;
                    end else begin
                        r[0] = sat_word(floor_quot(a[3] * one, det));
                        r[1] = sat_word(floor_quot(-a[1] * one, det));
                        r[2] = sat_word(floor_quot(-a[2] * one, det));
                        r[3] = sat_word(floor_quot(a[0] * one, det));
                    end
                end
                OP_EQ: begin
                    e.flag = 1'b1;
                    for (int i = 0; i < 4; i++) begin
                        diff = a[i] - b[i];
                        if (diff < 0) diff = -diff;
                        if (diff > longint'(c.tolerance)) e.flag = 1'b0;
                    end
                end
                default: ;
            endcase
            e.r_00 = r[0][31:0];
            e.r_01 = r[1][31:0];
            e.r_10 = r[2][31:0];
            e.r_11 = r[3][31:0];
            pending.push_back(e);
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.r_00 !== e.r_00) begin
                $display("%0t: r_00 expected %h actual %h", $realtime, e.r_00, got.r_00);
                errors++;
            end
            if (got.r_01 !== e.r_01) begin
                $display("%0t: r_01 expected %h actual %h", $realtime, e.r_01, got.r_01);
                errors++;
            end
            if (got.r_10 !== e.r_10) begin
                $display("%0t: r_10 expected %h actual %h", $realtime, e.r_10, got.r_10);
                errors++;
            end
            if (got.r_11 !== e.r_11) begin
                $display("%0t: r_11 expected %h actual %h", $realtime, e.r_11, got.r_11);
                errors++;
            end
            if (got.flag !== e.flag) begin
                $display("%0t: flag expected %b actual %b", $realtime, e.flag, got.flag);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_in_item         i_item;
    logic             o_valid;
    t_out_item        o_result;
    matrix_scoreboard sb;
    int               idle_cycles;
    int               burst_left;

    matrix2x2_fixed_alu_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_result);
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("matrix2x2_fixed_alu_core test failed");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        case ($urandom_range(0, 9))
            0: w = 32'h7fffffff;
            1: w = 32'h80000000;
            2: w = 32'h0;
            3: w = Q_ONE;
            4: w = -Q_ONE;
            5, 6: w = 32'($signed($urandom_range(0, 32'h7ffff)) - 32'sh40000);
            7: w = 32'($signed($urandom_range(0, 32'h1fffff)) - 32'sh100000);
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // one transaction, with bursts and random gaps between them
    task automatic send_command(t_in_item c);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        start  <= 1'b1;
        i_item <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_command(c);
        burst_left--;
    endtask

    task automatic send_random(logic [2:0] op);
        t_in_item c;
        c.opcode = op;
        c.a_00 = rand_word(); c.a_01 = rand_word();
        c.a_10 = rand_word(); c.a_11 = rand_word();
        c.scale_factor = rand_word();
        if ($urandom_range(0, 2) == 0 && op == OP_EQ) begin
            // near-equal matrices so the tolerance decides
            c.b_00 = c.a_00 + 32'($urandom_range(0, 64)) - 32;
            c.b_01 = c.a_01 + 32'($urandom_range(0, 64)) - 32;
            c.b_10 = c.a_10 + 32'($urandom_range(0, 64)) - 32;
            c.b_11 = c.a_11 + 32'($urandom_range(0, 64)) - 32;
            c.tolerance = 31'($urandom_range(0, 40));
        end else begin
            c.b_00 = rand_word(); c.b_01 = rand_word();
            c.b_10 = rand_word(); c.b_11 = rand_word();
            c.tolerance = $urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 255));
        end
        if (op == OP_INV && $urandom_range(0, 3) == 0) begin
            // singular: second row a multiple of the first
            c.a_10 = c.a_00 <<< 1;
            c.a_11 = c.a_01 <<< 1;
        end
        send_command(c);
    endtask

    task automatic send_matrix(logic [2:0] op, logic [31:0] a0, logic [31:0] a1,
                               logic [31:0] a2, logic [31:0] a3, logic [31:0] bw,
                               logic [31:0] s, logic [30:0] tol);
        t_in_item c;
        c.opcode = op;
        c.a_00 = a0; c.a_01 = a1; c.a_10 = a2; c.a_11 = a3;
        c.b_00 = bw; c.b_01 = bw; c.b_10 = bw; c.b_11 = bw;
        c.scale_factor = s;
        c.tolerance = tol;
        send_command(c);
    endtask

    // stimulus
    initial begin
        sb = new();
        idle_cycles = 0;
        burst_left = 0;
        start   <= 1'b0;
        i_item  <= '0;
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every opcode, singular inverse, equality edge
        send_matrix(OP_ADD, 32'h7fffffff, 32'h80000000, 0, Q_ONE, 32'h7fffffff, 0, 0);
        send_matrix(OP_ADD, 32'h80000000, 32'h80000000, 1, 2, 32'h80000000, 0, 0);
        send_matrix(OP_SUB, 32'h80000000, 32'h7fffffff, 0, 5, 32'h7fffffff, 0, 0);
        send_matrix(OP_SUB, 32'h7fffffff, 0, -1, 5, 32'h80000000, 0, 0);
        send_matrix(OP_SCL, 32'h7fffffff, 32'h80000000, -1, 3, 0, 32'h7fffffff, 0);
        send_matrix(OP_SCL, 32'h80000000, -Q_ONE, -1, 1, 0, 32'h80000000, 0);
        send_matrix(OP_SCL, -3, 3, Q_ONE, -Q_ONE, 0, 32'h8000, 0);
        send_matrix(OP_MUL, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                    32'h7fffffff, 0, 0);
        send_matrix(OP_MUL, -1, 1, Q_ONE, -Q_ONE, 32'h80000000, 0, 0);
        send_matrix(OP_DET, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0, 0, 0);
        send_matrix(OP_DET, Q_ONE, 2, 3, Q_ONE, 0, 0, 0);
        send_matrix(OP_INV, Q_ONE, 0, 0, Q_ONE, 0, 0, 0);
        send_matrix(OP_INV, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0);
        send_matrix(OP_INV, 1, 0, 0, 1, 0, 0, 0);
        send_matrix(OP_INV, 256, 0, 0, 256, 0, 0, 0);
        send_matrix(OP_INV, 32'h80000000, 32'h7fffffff, 1, 32'h80000000, 0, 0, 0);
        send_matrix(OP_INV, 32'h7fffffff, 0, 0, -Q_ONE, 0, 0, 0);
        send_matrix(OP_EQ, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                    32'h80000000, 0, 31'h7fffffff);
        send_matrix(OP_EQ, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                    32'h80000000, 0, 31'h7ffffffe);
        send_matrix(OP_EQ, 5, 5, 5, 5, 5, 0, 0);
        send_matrix(OP_EQ, 5, 5, 5, 6, 5, 0, 0);
        send_matrix(3'd7, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                    32'hffffffff, 32'hffffffff, 31'h7fffffff);

        // random part
        for (int n = 0; n < RANDOM_ITEMS; n++) send_random(3'($urandom_range(0, 7)));

        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("matrix2x2_fixed_alu_core test passed");
        end else begin
            $display("matrix2x2_fixed_alu_core test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* matrix2x2_fixed_alu_core.f */
+incdir+rtl/core
rtl/core/mxa_pkg.sv
rtl/core/mxa_lane.sv
rtl/core/mxa_div.sv
rtl/core/matrix2x2_fixed_alu_core.sv
rtl/core/mxa_checker.sv
sim/matrix2x2_fixed_alu_core_tb.sv
